### rtl/jbt_pkg.sv
// Package: shared types, codes and byte helpers of the JSON byte tokenizer.
package jbt_pkg;

   localparam int JBT_MAX_DEPTH = 32;
   localparam int JBT_QUEUE_DEPTH = 4;

   typedef enum logic [3:0] {
      EV_OBJ_OPEN     = 4'd0,
      EV_OBJ_CLOSE    = 4'd1,
      EV_ARR_OPEN     = 4'd2,
      EV_ARR_CLOSE    = 4'd3,
      EV_KEY_CHAR     = 4'd4,
      EV_KEY_END      = 4'd5,
      EV_STR_CHAR     = 4'd6,
      EV_STR_END      = 4'd7,
      EV_NUM_CHAR     = 4'd8,
      EV_NUM_END_INT  = 4'd9,
      EV_NUM_END_FRAC = 4'd10,
      EV_TRUE         = 4'd11,
      EV_FALSE        = 4'd12,
      EV_NULL         = 4'd13,
      EV_ERROR        = 4'd14
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE        = 4'd0,
      ERR_INPUT_ENDED = 4'd1,
      ERR_NEWLINE     = 4'd2,
      ERR_COMMA_OBJ   = 4'd3,
      ERR_COMMA_ARR   = 4'd4,
      ERR_KEY_EXP     = 4'd5,
      ERR_BAD_KEY     = 4'd6,
      ERR_COLON       = 4'd7,
      ERR_BAD_NUM     = 4'd8,
      ERR_INVALID     = 4'd9,
      ERR_TOO_DEEP    = 4'd10
   } err_type;

   typedef enum logic [3:0] {
      PH_VALUE = 4'd0,
      PH_CONT  = 4'd1,
      PH_ITEM  = 4'd2,
      PH_KEYQ  = 4'd3,
      PH_KEYB  = 4'd4,
      PH_COLON = 4'd5,
      PH_STR   = 4'd6,
      PH_NUM   = 4'd7,
      PH_KW    = 4'd8
   } phase_type;

   localparam logic [1:0] KW_NONE  = 2'd0;
   localparam logic [1:0] KW_TRUE  = 2'd1;
   localparam logic [1:0] KW_FALSE = 2'd2;
   localparam logic [1:0] KW_NULL  = 2'd3;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  ch;
      logic [5:0]  level;
      err_type     code;
      logic        done;
      logic        last;
   } event_type;

   // up to two events caused by one input byte
   typedef struct packed {
      logic [1:0] cnt;
      event_type  ev1;
      event_type  ev0;
   } pack_type;

   function automatic event_type jbt_mk(kind_type k, logic [7:0] c, err_type e,
                                        logic d, logic [5:0] lv);
      event_type r;
      r.kind = k;
      r.ch = c;
      r.level = lv;
      r.code = e;
      r.done = d;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_key_char(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic logic [2:0] kw_len(logic [1:0] id);
      logic [2:0] r;
      unique case (id)
         KW_TRUE:  r = 3'd3;
         KW_FALSE: r = 3'd4;
         KW_NULL:  r = 3'd3;
         default:  r = 3'd0;
      endcase
      return r;
   endfunction

   // remaining letters of "true", "false", "null" after the first
   function automatic logic [7:0] kw_byte(logic [1:0] id, logic [2:0] pos);
      logic [7:0] r;
      r = 8'd0;
      unique case (id)
         KW_TRUE: begin
            unique case (pos)
               3'd0: r = "r";
               3'd1: r = "u";
               3'd2: r = "e";
               default: r = 8'd0;
            endcase
         end
         KW_FALSE: begin
            unique case (pos)
               3'd0: r = "a";
               3'd1: r = "l";
               3'd2: r = "s";
               3'd3: r = "e";
               default: r = 8'd0;
            endcase
         end
         KW_NULL: begin
            unique case (pos)
               3'd0: r = "u";
               3'd1: r = "l";
               3'd2: r = "l";
               default: r = 8'd0;
            endcase
         end
         default: r = 8'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/json_byte_tokenizer.sv
// Top level of the streaming JSON byte tokenizer.
// Takes one document byte per cycle on the req_ channel while req_ready is high, and gives
// token events on the rsp_ channel. The front end parses one byte each cycle it is
// accepted, keeping the container stack, string, number and keyword progress, and writes
// the one or two events the byte causes as one entry into a four-entry queue; bytes that
// cause no event write nothing. The back end sends one event per cycle from its output
// register while rsp_ready is high; sustained rate is one byte per cycle while most bytes
// give at most one event. req_ready drops only when the queue is full. A byte's first
// event passes through its queue entry and then the output register. A restart item
// clears the parse state and is then parsed as the first byte of a new document; after
// the top-level value completes or after an error, bytes give no events until restart.
// Container depth is limited by MAX_DEPTH; opening one more level is a too-deep error.
module json_byte_tokenizer
   import jbt_pkg::*;
#(
   parameter int MAX_DEPTH = JBT_MAX_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_event_kind,
   output logic [7:0] rsp_char_value,
   output logic [5:0] rsp_nesting_level,
   output logic [3:0] rsp_error_code,
   output logic       rsp_document_done,
   output logic       rsp_last_event
);

   logic      acc;
   logic      push;
   logic      full;
   logic      empty;
   logic      pop;
   pack_type  wpack;
   pack_type  rpack;
   event_type ev;

   assign acc = req_valid && req_ready;
   assign req_ready = !full;

   jbt_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
      .clock (clock),
      .reset (reset),
      .acc   (acc),
      .c     (req_in_byte),
      .eoi   (req_end_of_input),
      .rst   (req_restart),
      .push  (push),
      .pack  (wpack)
   );

   jbt_queue #(.DEPTH(JBT_QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (wpack),
      .full  (full),
      .pop   (pop),
      .empty (empty),
      .rdata (rpack)
   );

   jbt_back u_back (
      .clock (clock),
      .reset (reset),
      .empty (empty),
      .rdata (rpack),
      .pop   (pop),
      .valid (rsp_valid),
      .ready (rsp_ready),
      .ev    (ev)
   );

   assign rsp_event_kind    = ev.kind;
   assign rsp_char_value    = ev.ch;
   assign rsp_nesting_level = ev.level;
   assign rsp_error_code    = ev.code;
   assign rsp_document_done = ev.done;
   assign rsp_last_event    = ev.last;

endmodule

### rtl/jbt_front.sv
// Front end: takes one byte per cycle while acc is high, keeps the parse state, builds the event pair.
module jbt_front
   import jbt_pkg::*;
#(
   parameter int MAX_DEPTH = JBT_MAX_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       acc,
   input  logic [7:0] c,
   input  logic       eoi,
   input  logic       rst,
   output logic       push,
   output pack_type   pack
);

   localparam int SPW = $clog2(MAX_DEPTH + 1);
   localparam int IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [MAX_DEPTH-1:0] stk_ff;
   logic [SPW-1:0] sp_ff, sp_in;
   phase_type      phase_ff, phase_in;
   logic           first_ff, first_in;
   logic [7:0]     quote_ff, quote_in;
   logic           esc_ff, esc_in;
   logic           dot_ff, dot_in;
   logic [1:0]     kid_ff, kid_in;
   logic [2:0]     kpos_ff, kpos_in;
   logic           stop_ff, stop_in;
   logic           st_en;
   logic [IW-1:0]  st_idx;
   logic           st_val;

   always_comb begin
      event_type  ev [2];
      logic [1:0] cnt;
      logic       redo;
      logic       obj;
      logic       closed;
      kind_type   ck;
      logic [SPW-1:0] spm1;
      sp_in = sp_ff;
      phase_in = phase_ff;
      first_in = first_ff;
      quote_in = quote_ff;
      esc_in = esc_ff;
      dot_in = dot_ff;
      kid_in = kid_ff;
      kpos_in = kpos_ff;
      stop_in = stop_ff;
      st_en = 1'b0;
      st_idx = '0;
      st_val = 1'b0;
      ev[0] = '0;
      ev[1] = '0;
      cnt = 2'd0;
      redo = 1'b0;
      obj = 1'b0;
      closed = 1'b0;
      ck = EV_STR_CHAR;
      spm1 = '0;
      if (acc) begin
         if (rst) begin
            sp_in = '0;
            phase_in = PH_VALUE;
            first_in = 1'b1;
            quote_in = 8'd0;
            esc_in = 1'b0;
            dot_in = 1'b0;
            kid_in = KW_NONE;
            kpos_in = 3'd0;
            stop_in = 1'b0;
         end
         if (!stop_in) begin
            if (eoi) begin
               ev[0] = jbt_mk(EV_ERROR, 8'd0,
                              (phase_in == PH_KW) ? ERR_INVALID : ERR_INPUT_ENDED,
                              1'b0, 6'(sp_in));
               cnt = 2'd1;
               stop_in = 1'b1;
            end else begin
               for (int pass = 0; pass < 2; pass++) begin
                  if (pass == 0 || redo) begin
                     redo = 1'b0;
                     spm1 = sp_in - 1'b1;
                     obj = (sp_in != '0) ? stk_ff[spm1[IW-1:0]] : 1'b0;
                     unique case (phase_in)
                        PH_VALUE, PH_CONT, PH_ITEM: begin
                           logic do_start;
                           do_start = 1'b0;
                           if (is_blank(c)) begin
                           end else if (phase_in == PH_VALUE) begin
                              do_start = 1'b1;
                           end else if (c == (obj ? 8'h7D : 8'h5D)) begin
                              // close the current level
                              sp_in = spm1;
                              if (sp_in == '0) begin
                                 ev[cnt[0]] = jbt_mk(obj ? EV_OBJ_CLOSE : EV_ARR_CLOSE,
                                                     8'd0, ERR_NONE, 1'b1, 6'(sp_in));
                                 stop_in = 1'b1;
                              end else begin
                                 ev[cnt[0]] = jbt_mk(obj ? EV_OBJ_CLOSE : EV_ARR_CLOSE,
                                                     8'd0, ERR_NONE, 1'b0, 6'(sp_in));
                                 phase_in = PH_CONT;
                                 first_in = 1'b0;
                              end
                              cnt = cnt + 2'd1;
                           end else if (phase_in == PH_CONT && !first_in) begin
                              if (c == ",") begin
                                 phase_in = PH_ITEM;
                              end else begin
                                 ev[cnt[0]] = jbt_mk(EV_ERROR, 8'd0,
                                                     obj ? ERR_COMMA_OBJ : ERR_COMMA_ARR,
                                                     1'b0, 6'(sp_in));
                                 cnt = cnt + 2'd1;
                                 stop_in = 1'b1;
                              end
                           end else begin
                              first_in = 1'b0;
                              if (obj) begin
                                 if (c == "'" || c == "\"") begin
                                    quote_in = c;
                                    esc_in = 1'b0;
                                    phase_in = PH_KEYQ;
                                 end else if (is_key_char(c)) begin
                                    ev[cnt[0]] = jbt_mk(EV_KEY_CHAR, c, ERR_NONE, 1'b0,
                                                        6'(sp_in));
                                    cnt = cnt + 2'd1;
                                    phase_in = PH_KEYB;
                                 end else begin
                                    ev[cnt[0]] = jbt_mk(EV_ERROR, 8'd0,
                                                        (c == ":") ? ERR_KEY_EXP : ERR_BAD_KEY,
                                                        1'b0, 6'(sp_in));
                                    cnt = cnt + 2'd1;
                                    stop_in = 1'b1;
                                 end
                              end else begin
                                 do_start = 1'b1;
                              end
                           end
                           if (do_start) begin
                              if (c == "{" || c == "[") begin
                                 if (sp_in >= SPW'(MAX_DEPTH)) begin
                                    ev[cnt[0]] = jbt_mk(EV_ERROR, 8'd0, ERR_TOO_DEEP, 1'b0,
                                                        6'(sp_in));
                                    cnt = cnt + 2'd1;
                                    stop_in = 1'b1;
                                 end else begin
                                    st_en = 1'b1;
                                    st_idx = sp_in[IW-1:0];
                                    st_val = (c == "{");
                                    sp_in = sp_in + 1'b1;
                                    ev[cnt[0]] = jbt_mk((c == "{") ? EV_OBJ_OPEN : EV_ARR_OPEN,
                                                        8'd0, ERR_NONE, 1'b0, 6'(sp_in));
                                    cnt = cnt + 2'd1;
                                    phase_in = PH_CONT;
                                    first_in = 1'b1;
                                 end
                              end else if (c == "'" || c == "\"") begin
                                 quote_in = c;
                                 esc_in = 1'b0;
                                 phase_in = PH_STR;
                              end else if (is_digit(c) || c == "." || c == "-") begin
                                 dot_in = (c == ".");
                                 ev[cnt[0]] = jbt_mk(EV_NUM_CHAR, c, ERR_NONE, 1'b0,
                                                     6'(sp_in));
                                 cnt = cnt + 2'd1;
                                 phase_in = PH_NUM;
                              end else if (c == "t" || c == "f" || c == "n") begin
                                 kid_in = (c == "t") ? KW_TRUE : (c == "f") ? KW_FALSE : KW_NULL;
                                 kpos_in = 3'd0;
                                 phase_in = PH_KW;
                              end else begin
                                 ev[cnt[0]] = jbt_mk(EV_ERROR, 8'd0, ERR_INVALID, 1'b0,
                                                     6'(sp_in));
                                 cnt = cnt + 2'd1;
                                 stop_in = 1'b1;
                              end
                           end
                        end
                        PH_KEYQ, PH_STR: begin
                           ck = (phase_in == PH_KEYQ) ? EV_KEY_CHAR : EV_STR_CHAR;
                           closed = 1'b0;
                           if (c == 8'h0A || c == 8'h0D) begin
                              ev[cnt[0]] = jbt_mk(EV_ERROR, 8'd0, ERR_NEWLINE, 1'b0,
                                                  6'(sp_in));
                              cnt = cnt + 2'd1;
                              stop_in = 1'b1;
                           end else if (esc_in) begin
                              esc_in = 1'b0;
                              unique case (c)
                                 "\\", "'", "\"": ev[0] = jbt_mk(ck, c, ERR_NONE, 1'b0,
                                                                 6'(sp_in));
                                 "t": ev[0] = jbt_mk(ck, 8'h09, ERR_NONE, 1'b0, 6'(sp_in));
                                 "r": ev[0] = jbt_mk(ck, 8'h0D, ERR_NONE, 1'b0, 6'(sp_in));
                                 "n": ev[0] = jbt_mk(ck, 8'h0A, ERR_NONE, 1'b0, 6'(sp_in));
                                 "b": ev[0] = jbt_mk(ck, 8'h08, ERR_NONE, 1'b0, 6'(sp_in));
                                 "f": ev[0] = jbt_mk(ck, 8'h0C, ERR_NONE, 1'b0, 6'(sp_in));
                                 default: begin
                                    // unknown escape: backslash, then the byte itself
                                    ev[0] = jbt_mk(ck, "\\", ERR_NONE, 1'b0, 6'(sp_in));
                                    ev[1] = jbt_mk(ck, c, ERR_NONE, 1'b0, 6'(sp_in));
                                    cnt = 2'd1;
                                 end
                              endcase
                              cnt = cnt + 2'd1;
                           end else if (c == "\\") begin
                              esc_in = 1'b1;
                           end else if (c == quote_in) begin
                              closed = 1'b1;
                           end else begin
                              ev[0] = jbt_mk(ck, c, ERR_NONE, 1'b0, 6'(sp_in));
                              cnt = 2'd1;
                           end
                           if (closed) begin
                              if (phase_in == PH_KEYQ) begin
                                 ev[0] = jbt_mk(EV_KEY_END, 8'd0, ERR_NONE, 1'b0, 6'(sp_in));
                                 phase_in = PH_COLON;
                              end else if (sp_in == '0) begin
                                 ev[0] = jbt_mk(EV_STR_END, 8'd0, ERR_NONE, 1'b1, 6'(sp_in));
                                 stop_in = 1'b1;
                              end else begin
                                 ev[0] = jbt_mk(EV_STR_END, 8'd0, ERR_NONE, 1'b0, 6'(sp_in));
                                 phase_in = PH_CONT;
                                 first_in = 1'b0;
                              end
                              cnt = 2'd1;
                           end
                        end
                        PH_KEYB: begin
                           if (is_key_char(c)) begin
                              ev[0] = jbt_mk(EV_KEY_CHAR, c, ERR_NONE, 1'b0, 6'(sp_in));
                           end else begin
                              ev[0] = jbt_mk(EV_KEY_END, 8'd0, ERR_NONE, 1'b0, 6'(sp_in));
                              phase_in = PH_COLON;
                              redo = (pass == 0);
                           end
                           cnt = 2'd1;
                        end
                        PH_COLON: begin
                           if (c == ":") begin
                              phase_in = PH_VALUE;
                           end else if (!is_blank(c)) begin
                              ev[cnt[0]] = jbt_mk(EV_ERROR, 8'd0, ERR_COLON, 1'b0, 6'(sp_in));
                              cnt = cnt + 2'd1;
                              stop_in = 1'b1;
                           end
                        end
                        PH_NUM: begin
                           if (c == ".") begin
                              if (dot_in) begin
                                 ev[0] = jbt_mk(EV_ERROR, 8'd0, ERR_BAD_NUM, 1'b0, 6'(sp_in));
                                 stop_in = 1'b1;
                              end else begin
                                 dot_in = 1'b1;
                                 ev[0] = jbt_mk(EV_NUM_CHAR, c, ERR_NONE, 1'b0, 6'(sp_in));
                              end
                           end else if (is_digit(c)) begin
                              ev[0] = jbt_mk(EV_NUM_CHAR, c, ERR_NONE, 1'b0, 6'(sp_in));
                           end else if (sp_in == '0) begin
                              ev[0] = jbt_mk(dot_in ? EV_NUM_END_FRAC : EV_NUM_END_INT, 8'd0,
                                             ERR_NONE, 1'b1, 6'(sp_in));
                              stop_in = 1'b1;
                           end else begin
                              // number ended: this byte is the next token
                              ev[0] = jbt_mk(dot_in ? EV_NUM_END_FRAC : EV_NUM_END_INT, 8'd0,
                                             ERR_NONE, 1'b0, 6'(sp_in));
                              phase_in = PH_CONT;
                              first_in = 1'b0;
                              redo = (pass == 0);
                           end
                           cnt = 2'd1;
                        end
                        PH_KW: begin
                           if (kid_in == KW_NONE || kpos_in >= kw_len(kid_in) ||
                               c != kw_byte(kid_in, kpos_in)) begin
                              ev[0] = jbt_mk(EV_ERROR, 8'd0, ERR_INVALID, 1'b0, 6'(sp_in));
                              cnt = 2'd1;
                              stop_in = 1'b1;
                           end else begin
                              kpos_in = kpos_in + 3'd1;
                              if (kpos_in == kw_len(kid_in)) begin
                                 ev[0] = jbt_mk(kind_type'(4'd10 + {2'd0, kid_in}), 8'd0,
                                                ERR_NONE, sp_in == '0, 6'(sp_in));
                                 cnt = 2'd1;
                                 if (sp_in == '0) begin
                                    stop_in = 1'b1;
                                 end else begin
                                    phase_in = PH_CONT;
                                    first_in = 1'b0;
                                 end
                              end
                           end
                        end
                        default: begin
                           ev[0] = jbt_mk(EV_ERROR, 8'd0, ERR_INVALID, 1'b0, 6'(sp_in));
                           cnt = 2'd1;
                           stop_in = 1'b1;
                        end
                     endcase
                  end
               end
            end
         end
      end
      if (cnt == 2'd1) ev[0].last = 1'b1;
      if (cnt == 2'd2) ev[1].last = 1'b1;
      pack.cnt = cnt;
      pack.ev0 = ev[0];
      pack.ev1 = ev[1];
      push = acc && (cnt != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
         phase_ff <= PH_VALUE;
         first_ff <= 1'b1;
         quote_ff <= 8'd0;
         esc_ff <= 1'b0;
         dot_ff <= 1'b0;
         kid_ff <= KW_NONE;
         kpos_ff <= 3'd0;
         stop_ff <= 1'b0;
      end else begin
         sp_ff <= sp_in;
         phase_ff <= phase_in;
         first_ff <= first_in;
         quote_ff <= quote_in;
         esc_ff <= esc_in;
         dot_ff <= dot_in;
         kid_ff <= kid_in;
         kpos_ff <= kpos_in;
         stop_ff <= stop_in;
      end
   end

   // level kinds are only read below the stack pointer, so need no reset
   always_ff @(posedge clock) begin
      if (st_en) stk_ff[st_idx] <= st_val;
   end

endmodule

### rtl/jbt_queue.sv
// Short FIFO of event pairs between front and back end.
module jbt_queue
   import jbt_pkg::*;
#(
   parameter int DEPTH = JBT_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  pack_type wdata,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output pack_type rdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pack_type       mem_ff [DEPTH];
   logic [AW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign rdata = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wdata;
   end

endmodule

### rtl/jbt_back.sv
// Back end: sends the queued events one per cycle while ready is high, from an output register.
module jbt_back
   import jbt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      empty,
   input  pack_type  rdata,
   output logic      pop,
   output logic      valid,
   input  logic      ready,
   output event_type ev
);

   logic     hold_ff, hold_in;
   logic     idx_ff, idx_in;
   pack_type cur_ff, cur_in;
   logic     at_last;
   logic     load;

   assign at_last = (cur_ff.cnt == 2'd1) || idx_ff;
   assign load    = !hold_ff || (ready && at_last);
   assign pop     = load && !empty;
   assign valid   = hold_ff;
   assign ev      = idx_ff ? cur_ff.ev1 : cur_ff.ev0;

   always_comb begin
      hold_in = hold_ff;
      idx_in = idx_ff;
      cur_in = cur_ff;
      if (load) begin
         hold_in = !empty;
         idx_in = 1'b0;
         cur_in = rdata;
      end else if (ready) begin
         idx_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         idx_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

### rtl/jbt_checker.sv
// Port checks of the tokenizer, bound to the top level.
module jbt_checker
   import jbt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_byte,
   input logic       req_end_of_input,
   input logic       req_restart,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_event_kind,
   input logic [7:0] rsp_char_value,
   input logic [5:0] rsp_nesting_level,
   input logic [3:0] rsp_error_code,
   input logic       rsp_document_done,
   input logic       rsp_last_event
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_in_byte) &&
      $stable(req_end_of_input) && $stable(req_restart))
      else $error("req item changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind))
      else $error("rsp item dropped while stalled");

   a_code_only_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind == EV_ERROR) == (rsp_error_code != ERR_NONE))
      else $error("error code does not match event kind");

   a_char_only_chars: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_KEY_CHAR && rsp_event_kind != EV_STR_CHAR &&
      rsp_event_kind != EV_NUM_CHAR |-> rsp_char_value == 8'd0)
      else $error("char value on a non-char event");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_document_done |-> rsp_last_event && rsp_nesting_level == 6'd0)
      else $error("document done not on last top-level event");

endmodule

bind json_byte_tokenizer jbt_checker u_chk (.*);
